>>> design/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, register indexes and helpers for the sphere / cylinder
// contact pipeline.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int COORD_W       = 32;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int LEN_W         = 31;
   localparam int NORM_W        = 18;
   localparam int PEN_W         = 32;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 32;

   localparam int RAD_W         = 64;
   localparam int ROOT_W        = 32;
   localparam int SQ_STEPS      = ROOT_W;

   localparam int DIV_NUM_W     = 48;
   localparam int DIV_DEN_W     = 32;
   localparam int DIV_Q_W       = 17;

   localparam int WIDE_W        = 36;

   localparam logic [LEN_W-1:0] LEN_RESET = 31'd65536;
   localparam logic [DIV_Q_W-1:0] Q_ONE   = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_CYL_RADIUS      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_HALF_HEIGHT = 8'd1;

   function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
      logic [COORD_W-1:0] neg;
      neg = COORD_W'(-v);
      return v[COORD_W-1] ? neg : COORD_W'(v);
   endfunction

   function automatic logic signed [NORM_W-1:0] apply_sign(input logic neg,
                                                           input logic [DIV_Q_W-1:0] m);
      logic signed [NORM_W-1:0] p;
      p = $signed({1'b0, m});
      return neg ? -p : p;
   endfunction

   function automatic logic signed [PEN_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7FFF_FFFF);
      lo = -(WIDE_W'(33'sh0_8000_0000));
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[PEN_W-1:0];
   endfunction

endpackage

>>> design/scc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Channel interfaces: sphere query words, contact result words and the
// register write port.
// ----------------------------------------------------------------------------
interface scc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [scc_pkg::COORD_W-1:0]   center_x;
   logic signed [scc_pkg::COORD_W-1:0]   center_y;
   logic signed [scc_pkg::COORD_W-1:0]   center_z;
   logic [scc_pkg::LEN_W-1:0]            sphere_radius;
   modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
   modport sink (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface scc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic                                 center_inside;
   logic signed [scc_pkg::NORM_W-1:0]    normal_x;
   logic signed [scc_pkg::NORM_W-1:0]    normal_y;
   logic signed [scc_pkg::NORM_W-1:0]    normal_z;
   logic signed [scc_pkg::PEN_W-1:0]     penetration;
   modport source (output valid, hit, center_inside, normal_x, normal_y, normal_z,
                   penetration, input ready);
   modport sink (input valid, hit, center_inside, normal_x, normal_y, normal_z,
                 penetration, output ready);
endinterface

interface scc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [scc_pkg::CSR_IDX_W-1:0]        index;
   logic [scc_pkg::CSR_DATA_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/scc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_sqrt
// Pipelined integer floor square root, one result bit per stage, with a
// sideband word that travels alongside.
// ----------------------------------------------------------------------------
module scc_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         vld_i,
   input  logic [scc_pkg::RAD_W-1:0]    rad_i,
   input  logic [SIDE_W-1:0]            side_i,
   output logic                         vld_o,
   output logic [scc_pkg::ROOT_W-1:0]   root_o,
   output logic [SIDE_W-1:0]            side_o
);
   import scc_pkg::*;

   logic [RAD_W-1:0]    rem_ff  [SQ_STEPS];
   logic [RAD_W-1:0]    res_ff  [SQ_STEPS];
   logic [SIDE_W-1:0]   side_ff [SQ_STEPS];
   logic [SQ_STEPS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQ_STEPS-2:0], vld_i};
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W-1:0]  rem_cur;
      logic [RAD_W-1:0]  res_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [RAD_W-1:0]  trial;
      logic [RAD_W-1:0]  rem_in;
      logic [RAD_W-1:0]  res_in;

      if (k == 0) begin : g_first
         assign rem_cur  = rad_i;
         assign res_cur  = '0;
         assign side_cur = side_i;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign res_cur  = res_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      always_comb begin
         trial = res_cur + BIT;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign vld_o  = vld_ff[SQ_STEPS-1];
   assign root_o = res_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign side_o = side_ff[SQ_STEPS-1];

endmodule

>>> design/scc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_div
// Pipelined restoring divider, one quotient bit per stage, for quotients
// known to fit in 17 bits, with a sideband word alongside.
// ----------------------------------------------------------------------------
module scc_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          vld_i,
   input  logic [scc_pkg::DIV_NUM_W-1:0] num_i,
   input  logic [scc_pkg::DIV_DEN_W-1:0] den_i,
   input  logic [SIDE_W-1:0]             side_i,
   output logic                          vld_o,
   output logic [scc_pkg::DIV_Q_W-1:0]   quo_o,
   output logic [SIDE_W-1:0]             side_o
);
   import scc_pkg::*;

   localparam int RW = DIV_DEN_W + DIV_Q_W;

   logic [RW-1:0]        rem_ff  [DIV_Q_W];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_ff  [DIV_Q_W];
   logic [SIDE_W-1:0]    side_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0]   vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_Q_W-2:0], vld_i};
      end
   end

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
      localparam int SH = DIV_Q_W - 1 - k;
      logic [RW-1:0]        rem_cur;
      logic [DIV_DEN_W-1:0] den_cur;
      logic [DIV_Q_W-1:0]   quo_cur;
      logic [SIDE_W-1:0]    side_cur;
      logic [RW-1:0]        dsh;
      logic [RW-1:0]        rem_in;
      logic [DIV_Q_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign rem_cur  = RW'(num_i);
         assign den_cur  = den_i;
         assign quo_cur  = '0;
         assign side_cur = side_i;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign den_cur  = den_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      always_comb begin
         dsh = RW'(den_cur) << SH;
         if (rem_cur >= dsh) begin
            rem_in = rem_cur - dsh;
            quo_in = quo_cur | (DIV_Q_W'(1) << SH);
         end else begin
            rem_in = rem_cur;
            quo_in = quo_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_cur;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign vld_o  = vld_ff[DIV_Q_W-1];
   assign quo_o  = quo_ff[DIV_Q_W-1];
   assign side_o = side_ff[DIV_Q_W-1];

endmodule

>>> design/sphere_cylinder_contact.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cylinder_contact
// Sphere against finite cylinder contact test in the cylinder frame:
// contact flags, unit normal and penetration depth in Q16.16.
//
//   channel  dir  handshake     word
//   req_ch   in   valid/ready   centre x/y/z, sphere radius
//   rsp_ch   out  valid/ready   hit, inside flag, normal x/y/z, penetration
//   csr_ch   in   valid/ready   register index, write data (ready always high)
//
// one word accepted per cycle while the pipeline is not stalled
// the path holds two 32-stage square root pipelines and two ranks of 17-stage dividers
// the whole pipeline advances together while the output register is free or taken
// a stall freezes every stage; bubbles are not squeezed out
// synchronous reset clears the valid bits and sets both lengths to 1.0
// ----------------------------------------------------------------------------
module sphere_cylinder_contact #(
   parameter int COORD_WIDTH = scc_pkg::COORD_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   scc_req_if.sink   req_ch,
   scc_rsp_if.source rsp_ch,
   scc_csr_if.sink   csr_ch
);
   import scc_pkg::*;

   localparam int EXT_W = (COORD_WIDTH > COORD_W) ? COORD_W : COORD_WIDTH;
   localparam int EXT_SH = COORD_W - EXT_W;

   typedef struct packed {
      logic [RAD_W-1:0]          rho_sq;
      logic signed [COORD_W-1:0] y;
      logic [COORD_W-1:0]        ay;
      logic [COORD_W-1:0]        ax;
      logic [COORD_W-1:0]        az;
      logic                      x_neg;
      logic                      z_neg;
      logic [LEN_W-1:0]          s;
      logic [2*LEN_W-1:0]        s_sq;
   } side1_type;

   typedef struct packed {
      logic                      enclosed;
      logic                      gate;
      logic [COORD_W-1:0]        e;
      logic [COORD_W-1:0]        ady;
      logic                      dy_neg;
      logic [ROOT_W-1:0]         rho;
      logic [COORD_W-1:0]        ax;
      logic [COORD_W-1:0]        az;
      logic                      x_neg;
      logic                      z_neg;
      logic                      y_neg;
      logic [COORD_W-1:0]        ay;
      logic [LEN_W-1:0]          s;
      logic [2*LEN_W-1:0]        s_sq;
   } stage4_type;

   typedef struct packed {
      logic                      hit;
      logic                      enclosed;
      logic                      surface;
      logic                      cap_lt;
      logic signed [WIDE_W-1:0]  pen_surf;
      logic [COORD_W-1:0]        e;
      logic [COORD_W-1:0]        ady;
      logic                      dy_neg;
      logic [ROOT_W-1:0]         rho;
      logic [COORD_W-1:0]        ax;
      logic [COORD_W-1:0]        az;
      logic                      x_neg;
      logic                      z_neg;
      logic                      y_neg;
      logic [LEN_W-1:0]          s;
   } side2_type;

   typedef struct packed {
      side2_type                 c;
      logic [ROOT_W-1:0]         sep;
   } side3_type;

   typedef struct packed {
      side3_type                 c;
      logic [DIV_Q_W-1:0]        ux;
      logic [DIV_Q_W-1:0]        uz;
      logic [DIV_Q_W-1:0]        qy;
   } side4_type;

   // registers and handshake
   logic [LEN_W-1:0]   cyl_radius_ff;
   logic [LEN_W-1:0]   cyl_half_height_ff;
   logic [2*LEN_W-1:0] r_sq_ff;
   logic               adv;
   logic               rsp_vld_ff;

   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_radius_ff      <= LEN_RESET;
         cyl_half_height_ff <= LEN_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CYL_RADIUS:      cyl_radius_ff      <= csr_ch.data[LEN_W-1:0];
            CSR_CYL_HALF_HEIGHT: cyl_half_height_ff <= csr_ch.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r_sq_ff <= cyl_radius_ff * cyl_radius_ff;
   end

   // stage 1: capture and sign extension
   logic                      s1_vld_ff;
   logic signed [COORD_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [LEN_W-1:0]          s1_s_ff;
   logic signed [COORD_W-1:0] x_in, y_in, z_in;

   assign x_in = $signed(req_ch.center_x << EXT_SH) >>> EXT_SH;
   assign y_in = $signed(req_ch.center_y << EXT_SH) >>> EXT_SH;
   assign z_in = $signed(req_ch.center_z << EXT_SH) >>> EXT_SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff <= x_in;
         s1_y_ff <= y_in;
         s1_z_ff <= z_in;
         s1_s_ff <= req_ch.sphere_radius;
      end
   end

   // stage 2: squares
   logic               s2_vld_ff;
   logic [RAD_W-1:0]   s2_axsq_ff, s2_azsq_ff;
   side1_type          s2_side_ff;
   logic [COORD_W-1:0] ax1, ay1, az1;
   logic [RAD_W-1:0]   axsq_in, azsq_in;
   logic [2*LEN_W-1:0] ssq_in;

   assign ax1     = mag32(s1_x_ff);
   assign ay1     = mag32(s1_y_ff);
   assign az1     = mag32(s1_z_ff);
   assign axsq_in = ax1 * ax1;
   assign azsq_in = az1 * az1;
   assign ssq_in  = s1_s_ff * s1_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_axsq_ff        <= axsq_in;
         s2_azsq_ff        <= azsq_in;
         s2_side_ff.rho_sq <= '0;
         s2_side_ff.y      <= s1_y_ff;
         s2_side_ff.ay     <= ay1;
         s2_side_ff.ax     <= ax1;
         s2_side_ff.az     <= az1;
         s2_side_ff.x_neg  <= s1_x_ff[COORD_W-1];
         s2_side_ff.z_neg  <= s1_z_ff[COORD_W-1];
         s2_side_ff.s      <= s1_s_ff;
         s2_side_ff.s_sq   <= ssq_in;
      end
   end

   // stage 3: radial distance squared
   logic      s3_vld_ff;
   side1_type s3_side_ff;
   side1_type s3_side_in;

   always_comb begin
      s3_side_in        = s2_side_ff;
      s3_side_in.rho_sq = s2_axsq_ff + s2_azsq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s3_side_in;
      end
   end

   // radial square root
   logic              sq1_vld;
   logic [ROOT_W-1:0] sq1_rho;
   side1_type         sq1_side;

   scc_sqrt #(.SIDE_W($bits(side1_type))) u_sqrt_rho (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (s3_vld_ff),
      .rad_i  (s3_side_ff.rho_sq),
      .side_i (s3_side_ff),
      .vld_o  (sq1_vld),
      .root_o (sq1_rho),
      .side_o (sq1_side)
   );

   // stage 4: classification and axial overshoot
   logic                      s4_vld_ff;
   stage4_type                s4_ff;
   stage4_type                s4_in;
   logic signed [COORD_W:0]   y_w, h_w;
   logic signed [COORD_W:0]   dy_hi, dy_lo;
   logic                      outside;

   always_comb begin
      y_w     = {sq1_side.y[COORD_W-1], sq1_side.y};
      h_w     = $signed({2'b00, cyl_half_height_ff});
      dy_hi   = y_w - h_w;
      dy_lo   = -(y_w + h_w);
      outside = sq1_side.rho_sq > RAD_W'(r_sq_ff);
      s4_in.enclosed = (sq1_side.rho_sq < RAD_W'(r_sq_ff)) &&
                       (sq1_side.ay < COORD_W'(cyl_half_height_ff));
      s4_in.dy_neg = y_w < -h_w;
      if (y_w > h_w) begin
         s4_in.ady = dy_hi[COORD_W-1:0];
      end else if (s4_in.dy_neg) begin
         s4_in.ady = dy_lo[COORD_W-1:0];
      end else begin
         s4_in.ady = '0;
      end
      s4_in.e     = outside ? (sq1_rho - COORD_W'(cyl_radius_ff)) : '0;
      s4_in.gate  = !s4_in.enclosed &&
                    ((s4_in.e >= COORD_W'(sq1_side.s)) || (s4_in.ady >= COORD_W'(sq1_side.s)));
      s4_in.rho   = sq1_rho;
      s4_in.ax    = sq1_side.ax;
      s4_in.az    = sq1_side.az;
      s4_in.x_neg = sq1_side.x_neg;
      s4_in.z_neg = sq1_side.z_neg;
      s4_in.y_neg = sq1_side.y[COORD_W-1];
      s4_in.ay    = sq1_side.ay;
      s4_in.s     = sq1_side.s;
      s4_in.s_sq  = sq1_side.s_sq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= sq1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff <= s4_in;
      end
   end

   // stage 5: squares of the radial gap and axial overshoot, cap and radial depths
   logic                     s5_vld_ff;
   stage4_type               s5_ff;
   logic [RAD_W-1:0]         s5_esq_ff, s5_adysq_ff;
   logic signed [WIDE_W-1:0] s5_cap_ff, s5_radial_ff;
   logic [RAD_W-1:0]         esq_in, adysq_in;
   logic signed [WIDE_W-1:0] cap_in, radial_in;

   assign esq_in    = s4_ff.e * s4_ff.e;
   assign adysq_in  = s4_ff.ady * s4_ff.ady;
   assign cap_in    = $signed(WIDE_W'(cyl_half_height_ff)) - $signed(WIDE_W'(s4_ff.ay));
   assign radial_in = $signed(WIDE_W'(cyl_radius_ff)) - $signed(WIDE_W'(s4_ff.rho));

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_ff        <= s4_ff;
         s5_esq_ff    <= esq_in;
         s5_adysq_ff  <= adysq_in;
         s5_cap_ff    <= cap_in;
         s5_radial_ff <= radial_in;
      end
   end

   // stage 6: contact decision
   logic             s6_vld_ff;
   logic [RAD_W-1:0] s6_d2_ff;
   side2_type        s6_side_ff;
   logic [RAD_W-1:0] d2_in;
   side2_type        s6_in;

   always_comb begin
      d2_in          = s5_ff.gate ? '0 : (s5_esq_ff + s5_adysq_ff);
      s6_in.enclosed = s5_ff.enclosed;
      s6_in.hit      = s5_ff.enclosed || (!s5_ff.gate && (d2_in < RAD_W'(s5_ff.s_sq)));
      s6_in.surface  = s5_ff.enclosed || (d2_in == '0);
      s6_in.cap_lt   = s5_cap_ff < s5_radial_ff;
      s6_in.pen_surf = $signed(WIDE_W'(s5_ff.s)) + (s6_in.cap_lt ? s5_cap_ff : s5_radial_ff);
      s6_in.e        = s5_ff.e;
      s6_in.ady      = s5_ff.ady;
      s6_in.dy_neg   = s5_ff.dy_neg;
      s6_in.rho      = s5_ff.rho;
      s6_in.ax       = s5_ff.ax;
      s6_in.az       = s5_ff.az;
      s6_in.x_neg    = s5_ff.x_neg;
      s6_in.z_neg    = s5_ff.z_neg;
      s6_in.y_neg    = s5_ff.y_neg;
      s6_in.s        = s5_ff.s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_d2_ff   <= d2_in;
         s6_side_ff <= s6_in;
      end
   end

   // distance square root
   logic              sq2_vld;
   logic [ROOT_W-1:0] sq2_sep;
   side2_type         sq2_side;
   side3_type         sq2_side3;

   scc_sqrt #(.SIDE_W($bits(side2_type))) u_sqrt_dist (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (s6_vld_ff),
      .rad_i  (s6_d2_ff),
      .side_i (s6_side_ff),
      .vld_o  (sq2_vld),
      .root_o (sq2_sep),
      .side_o (sq2_side)
   );

   assign sq2_side3.c   = sq2_side;
   assign sq2_side3.sep = sq2_sep;

   // unit radial direction and axial normal component
   logic               da_vld;
   logic [DIV_Q_W-1:0] da_ux, da_uz, da_qy;
   side3_type          da_side;

   scc_div #(.SIDE_W(1)) u_div_ux (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (sq2_vld),
      .num_i  ({sq2_side.ax, 16'd0}),
      .den_i  (sq2_side.rho),
      .side_i (1'b0),
      .vld_o  (),
      .quo_o  (da_ux),
      .side_o ()
   );

   scc_div #(.SIDE_W(1)) u_div_uz (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (sq2_vld),
      .num_i  ({sq2_side.az, 16'd0}),
      .den_i  (sq2_side.rho),
      .side_i (1'b0),
      .vld_o  (),
      .quo_o  (da_uz),
      .side_o ()
   );

   scc_div #(.SIDE_W($bits(side3_type))) u_div_ny (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (sq2_vld),
      .num_i  ({sq2_side.ady, 16'd0}),
      .den_i  (sq2_sep),
      .side_i (sq2_side3),
      .vld_o  (da_vld),
      .quo_o  (da_qy),
      .side_o (da_side)
   );

   // stage 7: scale the radial direction by the gap
   logic                   s7_vld_ff;
   side4_type              s7_side_ff;
   logic [DIV_NUM_W-1:0]   s7_mx_ff, s7_mz_ff;
   logic [DIV_Q_W+COORD_W-1:0] mx_in, mz_in;
   side4_type              s7_in;

   assign mx_in    = da_ux * da_side.c.e;
   assign mz_in    = da_uz * da_side.c.e;
   assign s7_in.c  = da_side;
   assign s7_in.ux = da_ux;
   assign s7_in.uz = da_uz;
   assign s7_in.qy = da_qy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= da_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_side_ff <= s7_in;
         s7_mx_ff   <= mx_in[DIV_NUM_W-1:0];
         s7_mz_ff   <= mz_in[DIV_NUM_W-1:0];
      end
   end

   // separated normal, x and z
   logic               db_vld;
   logic [DIV_Q_W-1:0] db_qx, db_qz;
   side4_type          db_side;

   scc_div #(.SIDE_W($bits(side4_type))) u_div_nx (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (s7_vld_ff),
      .num_i  (s7_mx_ff),
      .den_i  (s7_side_ff.c.sep),
      .side_i (s7_side_ff),
      .vld_o  (db_vld),
      .quo_o  (db_qx),
      .side_o (db_side)
   );

   scc_div #(.SIDE_W(1)) u_div_nz (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (s7_vld_ff),
      .num_i  (s7_mz_ff),
      .den_i  (s7_side_ff.c.sep),
      .side_i (1'b0),
      .vld_o  (),
      .quo_o  (db_qz),
      .side_o ()
   );

   // result selection and output register
   logic                     rsp_hit_ff, rsp_inside_ff;
   logic signed [NORM_W-1:0] rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic signed [PEN_W-1:0]  rsp_pen_ff;
   logic signed [NORM_W-1:0] nx_in, ny_in, nz_in;
   logic signed [WIDE_W-1:0] pen_in;
   side2_type                fb;
   logic                     rho_nz;

   always_comb begin
      fb     = db_side.c.c;
      rho_nz = fb.rho != '0;
      nx_in  = '0;
      ny_in  = '0;
      nz_in  = '0;
      pen_in = '0;
      if (fb.hit) begin
         if (fb.surface) begin
            pen_in = fb.pen_surf;
            if (fb.cap_lt) begin
               ny_in = apply_sign(fb.y_neg, Q_ONE);
            end else if (rho_nz) begin
               nx_in = apply_sign(fb.x_neg, db_side.ux);
               nz_in = apply_sign(fb.z_neg, db_side.uz);
            end else begin
               nx_in = apply_sign(1'b0, Q_ONE);
            end
         end else begin
            pen_in = $signed(WIDE_W'(fb.s)) - $signed(WIDE_W'(db_side.c.sep));
            ny_in  = apply_sign(fb.dy_neg, db_side.qy);
            if ((fb.e != '0) && rho_nz) begin
               nx_in = apply_sign(fb.x_neg, db_qx);
               nz_in = apply_sign(fb.z_neg, db_qz);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= db_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff    <= fb.hit;
         rsp_inside_ff <= fb.hit && fb.enclosed;
         rsp_nx_ff     <= nx_in;
         rsp_ny_ff     <= ny_in;
         rsp_nz_ff     <= nz_in;
         rsp_pen_ff    <= sat32(pen_in);
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.center_inside = rsp_inside_ff;
   assign rsp_ch.normal_x      = rsp_nx_ff;
   assign rsp_ch.normal_y      = rsp_ny_ff;
   assign rsp_ch.normal_z      = rsp_nz_ff;
   assign rsp_ch.penetration   = rsp_pen_ff;

   // checks
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_hit_ff |-> rsp_nx_ff == '0 && rsp_ny_ff == '0 &&
                                    rsp_nz_ff == '0 && rsp_pen_ff == '0 && !rsp_inside_ff)
      else $error("miss word carries non-zero fields");

   a_inside_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_inside_ff |-> rsp_hit_ff)
      else $error("inside flag without hit");

   a_normal_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_nx_ff <= 18'sd65536 && rsp_nx_ff >= -18'sd65536 &&
                     rsp_ny_ff <= 18'sd65536 && rsp_ny_ff >= -18'sd65536 &&
                     rsp_nz_ff <= 18'sd65536 && rsp_nz_ff >= -18'sd65536)
      else $error("normal component beyond unit length");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_vld_ff) && $stable(s6_vld_ff) && $stable(s7_vld_ff))
      else $error("pipeline moved during a stall");

endmodule

>>> dv/sphere_cylinder_contact_test_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cylinder_contact_test_if
// Holds only the contact_t word: the channel interfaces come with the design in scc_if.
// ----------------------------------------------------------------------------
package scc_test_pkg;
   typedef struct packed {
      logic                          hit;
      logic                          center_inside;
      logic signed [17:0]            normal_x;
      logic signed [17:0]            normal_y;
      logic signed [17:0]            normal_z;
      logic signed [31:0]            penetration;
   } contact_t;
endpackage

>>> dv/sphere_cylinder_contact_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cylinder_contact_test
// Drives sphere queries against several cylinder sizes, predicts each contact
// word in fixed point and checks every result word in order, under random
// idling on both channels.
// ----------------------------------------------------------------------------
module sphere_cylinder_contact_test;
   import scc_pkg::*;
   import scc_test_pkg::*;

   class contact_board;
      longint unsigned radius, half_height;
      contact_t pending[$];
      int errors;

      function new();
         radius = 65536;
         half_height = 65536;
         errors = 0;
      endfunction

      static function longint unsigned root(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      static function longint unsigned absval(longint v);
         return v < 0 ? -v : v;
      endfunction

      static function longint scale(longint num, longint unsigned mul,
                                    longint unsigned den);
         longint unsigned q;
         q = (absval(num) * mul) / den;
         return num < 0 ? -longint'(q) : longint'(q);
      endfunction

      function void note_query(logic signed [31:0] cx, logic signed [31:0] cy,
                               logic signed [31:0] cz, logic [30:0] sr);
         longint x, y, z, hh, rr, ss, clampy, dy, radial, cap, u, v, nx, ny, nz, pen;
         longint unsigned ax, ay, az, rho_sq, rho, e, ady, d2, sep;
         bit enclosed, outside, hit;
         contact_t c;
         x = cx; y = cy; z = cz;
         rr = radius; hh = half_height; ss = sr;
         ax = absval(x); ay = absval(y); az = absval(z);
         rho_sq = ax * ax + az * az;
         rho = root(rho_sq);
         outside = rho_sq > radius * radius;
         enclosed = rho_sq < radius * radius && ay < half_height;
         clampy = y < -hh ? -hh : (y > hh ? hh : y);
         dy = y - clampy;
         e = outside ? rho - radius : 0;
         ady = absval(dy);
         d2 = 0;
         nx = 0; ny = 0; nz = 0; pen = 0;
         if (enclosed) hit = 1;
         else if (e >= ss || ady >= ss) hit = 0;
         else begin
            d2 = e * e + ady * ady;
            hit = d2 < ss * ss;
         end
         if (hit) begin
            if (enclosed || d2 == 0) begin
               radial = rr - longint'(rho);
               cap = hh - longint'(ay);
               if (cap < radial) begin
                  ny = y >= 0 ? 65536 : -65536;
                  pen = ss + cap;
               end else begin
                  if (rho > 0) begin
                     nx = scale(x, 65536, rho);
                     nz = scale(z, 65536, rho);
                  end else begin
                     nx = 65536;
                  end
                  pen = ss + radial;
               end
            end else begin
               sep = root(d2);
               if (sep == 0) sep = 1;
               if (e != 0 && rho > 0) begin
                  u = scale(x, 65536, rho);
                  v = scale(z, 65536, rho);
                  nx = scale(u, e, sep);
                  nz = scale(v, e, sep);
               end
               ny = scale(dy, 65536, sep);
               pen = ss - longint'(sep);
            end
            if (pen > 64'sd2147483647) pen = 64'sd2147483647;
            if (pen < -64'sd2147483648) pen = -64'sd2147483648;
         end
         c.hit = hit;
         c.center_inside = hit && enclosed;
         c.normal_x = nx[17:0];
         c.normal_y = ny[17:0];
         c.normal_z = nz[17:0];
         c.penetration = pen[31:0];
         pending.insert(pending.size(), c);
      endfunction

      function void check_contact(contact_t got);
         contact_t want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected contact word %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            errors++;
         end
         if (got.center_inside !== want.center_inside) begin
            $display("%0t: center_inside expected %0d actual %0d", $time,
                     want.center_inside, got.center_inside);
            errors++;
         end
         if (got.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time,
                     want.normal_x, got.normal_x);
            errors++;
         end
         if (got.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time,
                     want.normal_y, got.normal_y);
            errors++;
         end
         if (got.normal_z !== want.normal_z) begin
            $display("%0t: normal_z expected %0d actual %0d", $time,
                     want.normal_z, got.normal_z);
            errors++;
         end
         if (got.penetration !== want.penetration) begin
            $display("%0t: penetration expected %0d actual %0d", $time,
                     want.penetration, got.penetration);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock, reset;
   int send_idle, stall_rate;
   int quiet_cycles;
   bit timed_out;
   contact_board board;

   scc_req_if req_ch();
   scc_rsp_if rsp_ch();
   scc_csr_if csr_ch();

   sphere_cylinder_contact i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.center_x = 0;
      req_ch.center_y = 0;
      req_ch.center_z = 0;
      req_ch.sphere_radius = 0;
      csr_ch.valid = 0;
      csr_ch.index = 0;
      csr_ch.data = 0;
      rsp_ch.ready = 0;
   end

   // result side: random stall, check on acceptance
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_contact({rsp_ch.hit, rsp_ch.center_inside, rsp_ch.normal_x,
                                 rsp_ch.normal_y, rsp_ch.normal_z, rsp_ch.penetration});
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_rate);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sphere_cylinder_contact regression: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [30:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= {1'b0, value};
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_CYL_RADIUS) board.radius = value;
      else board.half_height = value;
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] s);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.center_x <= x;
      req_ch.center_y <= y;
      req_ch.center_z <= z;
      req_ch.sphere_radius <= s;
      do @(posedge clock); while (!req_ch.ready);
      board.note_query(x, y, z, s);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(longint unsigned span);
      int k;
      k = $urandom_range(9);
      if (k == 0) return $urandom;
      if (k == 1) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (k == 2) return 0;
      return 32'(longint'($urandom_range(32'(2 * span))) - longint'(span));
   endfunction

   task automatic random_queries(int n, logic [30:0] r, logic [30:0] h);
      longint unsigned span;
      logic [30:0] s;
      span = (longint'(r) > longint'(h) ? r : h) * 2 + 65536;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      repeat (n) begin
         if ($urandom_range(7) == 0) s = 31'($urandom);
         else s = 31'($urandom_range(32'(span / 2)));
         send_query(pick_coord(span), pick_coord(span), pick_coord(span), s);
      end
   endtask

   initial begin
      logic [30:0] radii[5], heights[5];
      board = new();
      send_idle = 0;
      stall_rate = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset size, extremes, axis, caps, surface, far away
      send_query(0, 0, 0, 0);
      send_query(0, 0, 0, 31'h7FFF_FFFF);
      send_query(32'h0000_8000, 0, 0, 1000);
      send_query(0, 32'h0000_C000, 0, 1000);
      send_query(0, 32'hFFFF_4000, 0, 1000);
      send_query(32'h0001_0000, 0, 0, 1000);
      send_query(0, 32'h0001_0000, 0, 1000);
      send_query(32'h0001_0000, 32'h0001_0000, 0, 1000);
      send_query(32'h0001_8000, 0, 0, 31'h0001_0000);
      send_query(32'h0001_8000, 32'h0001_8000, 0, 31'h0001_0000);
      send_query(32'hFFFE_8000, 32'hFFFE_8000, 32'h0000_4000, 31'h0001_0000);
      send_query(0, 32'h0001_8000, 32'hFFFF_0000, 31'h0000_8000);
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      send_query(32'h0002_0000, 0, 0, 31'h0001_0000);
      send_query(0, 0, 32'hFFFF_FFFF, 5);
      drain();

      radii[0] = 0;            heights[0] = 0;
      radii[1] = 31'h7FFF_FFFF; heights[1] = 31'h7FFF_FFFF;
      radii[2] = 31'h0003_0000; heights[2] = 31'h0000_8000;
      radii[3] = 31'h0000_4000; heights[3] = 31'h0010_0000;
      radii[4] = 31'($urandom); heights[4] = 31'($urandom);
      write_reg(CSR_CYL_RADIUS, radii[0]);
      write_reg(CSR_CYL_HALF_HEIGHT, heights[0]);
      send_query(0, 0, 0, 0);
      send_query(0, 0, 0, 100);
      send_query(32'h0000_0064, 32'h0000_0010, 0, 200);
      send_query(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p != 0) begin
            write_reg(CSR_CYL_RADIUS, radii[p]);
            write_reg(CSR_CYL_HALF_HEIGHT, heights[p]);
         end
         for (int m = 0; m < 4; m++) begin
            send_idle = (m == 1 || m == 3) ? (m == 1 ? 67 : 11) : 0;
            stall_rate = (m == 2 || m == 3) ? (m == 2 ? 67 : 11) : 0;
            random_queries(70, radii[p], heights[p]);
         end
         drain();
      end
      write_reg(CSR_CYL_RADIUS, 31'h0001_0000);
      write_reg(CSR_CYL_HALF_HEIGHT, 31'h0001_0000);
      random_queries(30, 31'h0001_0000, 31'h0001_0000);
      drain();

      if (board.errors == 0) begin
         $display("sphere_cylinder_contact regression: pass");
      end else begin
         $display("sphere_cylinder_contact regression: fail");
      end
      $finish;
   end
endmodule
